// ===== design/efr_pkg.sv =====
// Package with shared types, constants and functions of the framed throttle receiver.
package efr_pkg;

    localparam int NUM_CHANNELS_DEF = 8;

    localparam logic [8:0]  ALPHA_RESET   = 9'd77;
    localparam logic [9:0]  STEP_RESET    = 10'd100;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    localparam logic [7:0]  SYNC_BYTE   = 8'hAA;
    localparam logic [7:0]  CMD_THROTTLE = 8'h01;
    localparam logic [10:0] PULSE_MID   = 11'd1500;
    localparam logic [10:0] PULSE_MIN   = 11'd1000;
    localparam logic [10:0] PULSE_MAX   = 11'd2000;

    localparam logic [1:0] ADDR_ALPHA   = 2'd0;
    localparam logic [1:0] ADDR_STEP    = 2'd1;
    localparam logic [1:0] ADDR_TIMEOUT = 2'd2;

    typedef enum logic [1:0] {
        MODE_BYTE    = 2'd0,
        MODE_APPLY   = 2'd1,
        MODE_CHECK   = 2'd2,
        MODE_TICK    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_FRAME   = 2'd0,
        KIND_PULSE   = 2'd1,
        KIND_TIMEOUT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_APPLIED = 3'd0,
        ST_SHORT   = 3'd1,
        ST_HEADER  = 3'd2,
        ST_LENGTH  = 3'd3,
        ST_CRC     = 3'd4,
        ST_IGNORED = 3'd5
    } frame_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_MUL,
        S_OUT,
        S_SINGLE
    } state_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] byte_data;
        logic       end_of_frame;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  frame_status;
        logic [2:0]  channel;
        logic [10:0] pulse_width;
        logic        timeout_active;
        logic        last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic byte_step;
        logic tick;
        logic zero_throttles;
        logic load_channel;
        logic calc_channel;
        logic write_channel;
        logic set_single;
        logic set_timeout_flag;
        logic clr_timeout_flag;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic timed_out;
    } dp_stat_t;

    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [10:0] target_of(input logic [15:0] raw);
        logic signed [15:0] v;
        logic [10:0] r;
        v = raw;
        if (v >= -16'sd100 && v <= 16'sd100) begin
            r = 11'(16'sd1500 + 16'(v * 16'sd5));
        end else if (v < 16'sd1000) begin
            r = PULSE_MIN;
        end else if (v > 16'sd2000) begin
            r = PULSE_MAX;
        end else begin
            r = v[10:0];
        end
        return r;
    endfunction

endpackage

// ===== design/efr_ctrl.sv =====
// Controller state machine that sequences frame bytes, events and per-channel results.
module efr_ctrl #(
    parameter int NUM_CHANNELS = efr_pkg::NUM_CHANNELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            in_mode,
    input  logic                  m_ready,
    output logic                  out_valid,
    output logic [2:0]            chan,
    output efr_pkg::dp_cmd_t      cmd,
    input  efr_pkg::dp_stat_t     stat
);

    efr_pkg::state_t state_reg, state_next;
    logic [2:0] chan_reg, chan_next;

    assign chan = chan_reg;

    always_comb begin
        state_next = state_reg;
        chan_next = chan_reg;
        case (state_reg)
            efr_pkg::S_IDLE: begin
                if (s_valid) begin
                    case (in_mode)
                        efr_pkg::MODE_APPLY: begin
                            state_next = efr_pkg::S_CALC;
                            chan_next = '0;
                        end
                        efr_pkg::MODE_CHECK: begin
                            chan_next = '0;
                            state_next = stat.timed_out ? efr_pkg::S_CALC
                                                        : efr_pkg::S_SINGLE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            efr_pkg::S_CALC: state_next = efr_pkg::S_MUL;
            efr_pkg::S_MUL:  state_next = efr_pkg::S_OUT;
            efr_pkg::S_OUT: begin
                if (m_ready) begin
                    if (32'(chan_reg) == NUM_CHANNELS - 1) begin
                        state_next = efr_pkg::S_IDLE;
                    end else begin
                        chan_next = chan_reg + 3'd1;
                        state_next = efr_pkg::S_CALC;
                    end
                end
            end
            efr_pkg::S_SINGLE: begin
                if (m_ready) begin
                    state_next = efr_pkg::S_IDLE;
                end
            end
            default: state_next = efr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            efr_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (in_mode)
                        efr_pkg::MODE_BYTE: begin
                            cmd.byte_step = 1'b1;
                            if (m_ready == 1'b0) begin
                            end
                        end
                        efr_pkg::MODE_APPLY: cmd.clr_timeout_flag = 1'b1;
                        efr_pkg::MODE_CHECK: begin
                            if (stat.timed_out) begin
                                cmd.zero_throttles = 1'b1;
                                cmd.set_timeout_flag = 1'b1;
                            end else begin
                                cmd.set_single = 1'b1;
                            end
                        end
                        default: cmd.tick = 1'b1;
                    endcase
                end
            end
            efr_pkg::S_CALC: cmd.load_channel = 1'b1;
            efr_pkg::S_MUL:  cmd.calc_channel = 1'b1;
            efr_pkg::S_OUT: begin
                out_valid = 1'b1;
                cmd.write_channel = m_ready;
            end
            efr_pkg::S_SINGLE: out_valid = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= efr_pkg::S_IDLE;
            chan_reg <= '0;
        end else begin
            state_reg <= state_next;
            chan_reg <= chan_next;
        end
    end

    a_chan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(chan_reg) < NUM_CHANNELS) else $error("channel index out of range");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !out_valid) else $error("input taken while result pending");
    a_out_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == efr_pkg::S_MUL) |=> (state_reg == efr_pkg::S_OUT))
        else $error("pulse result did not follow computation");

endmodule

// ===== design/efr_datapath.sv =====
// Datapath with frame parser, throttle stores, timeout timer and the pulse smoothing unit.
module efr_datapath #(
    parameter int NUM_CHANNELS = efr_pkg::NUM_CHANNELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  efr_pkg::dp_cmd_t      cmd,
    output efr_pkg::dp_stat_t     stat,
    input  logic [2:0]            chan,
    input  logic [7:0]            byte_data,
    input  logic                  end_of_frame,
    input  logic [8:0]            alpha_q8,
    input  logic [9:0]            max_step_us,
    input  logic [15:0]           timeout_limit,
    output efr_pkg::out_item_t    out_item
);

    localparam logic [15:0] PAY_END = 16'(3 + 2 * NUM_CHANNELS);

    logic [15:0] byte_count_reg;
    logic [7:0]  crc_reg;
    logic        header_ok_reg;
    logic [7:0]  command_reg;
    logic [7:0]  length_reg;
    logic [7:0]  low_hold_reg;
    logic [15:0] shadow_reg [8];
    logic [15:0] throttle_reg [8];
    logic [10:0] filt_reg [8];
    logic [31:0] elapsed_reg;
    logic        to_flag_reg;
    efr_pkg::out_item_t out_reg;

    logic [10:0] tgt_reg, old_reg;
    logic [8:0]  a_reg;
    logic [19:0] prod_next;
    logic [10:0] f_next;

    logic [16:0] len;
    logic [2:0]  status;
    logic        commit;
    logic [15:0] off;

    assign stat.timed_out = elapsed_reg > 32'(timeout_limit);
    assign out_item = out_reg;
    assign len = 17'(byte_count_reg) + 17'd1;
    assign off = byte_count_reg - 16'd3;

    always_comb begin
        commit = 1'b0;
        if (len < 17'd4) begin
            status = efr_pkg::ST_SHORT;
        end else if (!header_ok_reg) begin
            status = efr_pkg::ST_HEADER;
        end else if (17'(length_reg) + 17'd4 > len) begin
            status = efr_pkg::ST_LENGTH;
        end else if (crc_reg != byte_data) begin
            status = efr_pkg::ST_CRC;
        end else if (command_reg == efr_pkg::CMD_THROTTLE
                     && 32'(length_reg) == 2 * NUM_CHANNELS) begin
            status = efr_pkg::ST_APPLIED;
            commit = 1'b1;
        end else begin
            status = efr_pkg::ST_IGNORED;
        end
    end

    // Two products of at most 9 by 11 bits, summed then scaled by 1/256.
    logic [10:0] ema;
    logic [11:0] hi_lim;
    logic [11:0] lo_sum;
    always_comb begin
        prod_next = 20'(a_reg * tgt_reg) + 20'((9'd256 - a_reg) * old_reg);
        ema = prod_next[18:8];
        hi_lim = 12'(old_reg) + 12'(max_step_us);
        lo_sum = 12'(ema) + 12'(max_step_us);
        if (12'(ema) > hi_lim) begin
            f_next = hi_lim > 12'(efr_pkg::PULSE_MAX) ? efr_pkg::PULSE_MAX : hi_lim[10:0];
        end else if (lo_sum < 12'(old_reg)) begin
            f_next = 11'(12'(old_reg) - 12'(max_step_us));
        end else begin
            f_next = ema;
        end
        if (f_next < efr_pkg::PULSE_MIN) begin
            f_next = efr_pkg::PULSE_MIN;
        end
        if (f_next > efr_pkg::PULSE_MAX) begin
            f_next = efr_pkg::PULSE_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            crc_reg <= '0;
            header_ok_reg <= 1'b0;
            command_reg <= '0;
            length_reg <= '0;
            low_hold_reg <= '0;
            elapsed_reg <= '0;
            to_flag_reg <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                throttle_reg[i] <= '0;
                filt_reg[i] <= efr_pkg::PULSE_MID;
            end
        end else begin
            if (cmd.byte_step) begin
                if (end_of_frame) begin
                    if (commit) begin
                        for (int i = 0; i < NUM_CHANNELS; i++) begin
                            throttle_reg[i] <= shadow_reg[i];
                        end
                        elapsed_reg <= '0;
                    end
                    byte_count_reg <= '0;
                    crc_reg <= '0;
                    header_ok_reg <= 1'b0;
                    command_reg <= '0;
                    length_reg <= '0;
                    low_hold_reg <= '0;
                end else begin
                    if (byte_count_reg == 16'd0) begin
                        header_ok_reg <= byte_data == efr_pkg::SYNC_BYTE;
                    end else if (byte_count_reg == 16'd1) begin
                        command_reg <= byte_data;
                    end else if (byte_count_reg == 16'd2) begin
                        length_reg <= byte_data;
                    end else if (byte_count_reg < PAY_END && !off[0]) begin
                        low_hold_reg <= byte_data;
                    end
                    crc_reg <= efr_pkg::crc_update(crc_reg, byte_data);
                    if (byte_count_reg != 16'hFFFF) begin
                        byte_count_reg <= byte_count_reg + 16'd1;
                    end
                end
            end
            if (cmd.tick && elapsed_reg != 32'hFFFF_FFFF) begin
                elapsed_reg <= elapsed_reg + 32'd1;
            end
            if (cmd.zero_throttles) begin
                for (int i = 0; i < 8; i++) begin
                    throttle_reg[i] <= '0;
                end
            end
            if (cmd.set_timeout_flag) begin
                to_flag_reg <= 1'b1;
            end else if (cmd.clr_timeout_flag) begin
                to_flag_reg <= 1'b0;
            end
            if (cmd.write_channel) begin
                filt_reg[chan] <= out_reg.pulse_width;
            end
        end
    end

    // Shadow store is written by the frame parser only and needs no reset.
    always_ff @(posedge aclk) begin
        if (cmd.byte_step && !end_of_frame && byte_count_reg >= 16'd3
            && byte_count_reg < PAY_END && off[0]) begin
            shadow_reg[off[3:1]] <= {byte_data, low_hold_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_channel) begin
            tgt_reg <= efr_pkg::target_of(throttle_reg[chan]);
            old_reg <= filt_reg[chan];
            a_reg <= alpha_q8 > 9'd256 ? 9'd256 : alpha_q8;
        end
        if (cmd.byte_step && end_of_frame) begin
            out_reg <= '{kind: efr_pkg::KIND_FRAME, frame_status: status, channel: 3'd0,
                         pulse_width: 11'd0, timeout_active: 1'b0, last: 1'b1};
        end else if (cmd.set_single) begin
            out_reg <= '{kind: efr_pkg::KIND_TIMEOUT, frame_status: 3'd0, channel: 3'd0,
                         pulse_width: 11'd0, timeout_active: 1'b0, last: 1'b1};
        end else if (cmd.calc_channel) begin
            out_reg <= '{kind: efr_pkg::KIND_PULSE, frame_status: 3'd0, channel: chan,
                         pulse_width: f_next, timeout_active: to_flag_reg,
                         last: 32'(chan) == NUM_CHANNELS - 1};
        end
    end

    a_pulse_range: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.calc_channel) |-> (out_reg.pulse_width >= efr_pkg::PULSE_MIN
                                     && out_reg.pulse_width <= efr_pkg::PULSE_MAX))
        else $error("pulse out of range");
    a_commit_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.byte_step && end_of_frame && commit) |=> elapsed_reg == 32'd0)
        else $error("elapsed time not cleared on commit");
    a_frame_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.byte_step && end_of_frame) |=> byte_count_reg == 16'd0 && crc_reg == 8'd0)
        else $error("frame state not cleared at frame end");

endmodule

// ===== design/esc_frame_receiver_pwm_smoother_unit.sv =====
// Top level of the framed throttle receiver with smoothed pulse outputs.
// The input channel (s_valid, s_ready, s_data) takes one item per handshake:
// a frame byte, an apply event, a timeout check or a millisecond tick.
// The result channel (m_valid, m_ready, m_data) carries frame status,
// channel pulse and timeout status items.
// The last frame byte, or a timeout check that does not fire, gives its status
// item in the cycle after it is taken, and the block waits until that item is
// taken.
// An apply event or a fired timeout gives one pulse item per channel; each
// channel passes in turn through the shared smoothing unit (load, multiply,
// output register), and the output register holds while the receiver stalls.
// While the receiver holds m_ready low the current item stays on m_data and
// no new input item is taken.
// After reset the registers hold their defaults, throttles are zero and
// every filtered pulse is 1500 microseconds.
// The APB port writes the EMA weight, the step limit and the timeout at byte
// addresses 0, 4 and 8 and reads them back.
module esc_frame_receiver_pwm_smoother_unit #(
    parameter int NUM_CHANNELS = efr_pkg::NUM_CHANNELS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  efr_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output efr_pkg::out_item_t  m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [8:0]  alpha_reg;
    logic [9:0]  step_reg;
    logic [15:0] timeout_reg;
    logic        pend_reg;
    logic        ctrl_ready, ctrl_valid;
    logic [2:0]  chan;
    efr_pkg::dp_cmd_t  cmd;
    efr_pkg::dp_stat_t stat;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= efr_pkg::ALPHA_RESET;
            step_reg <= efr_pkg::STEP_RESET;
            timeout_reg <= efr_pkg::TIMEOUT_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                efr_pkg::ADDR_ALPHA:   alpha_reg <= pwdata[8:0];
                efr_pkg::ADDR_STEP:    step_reg <= pwdata[9:0];
                efr_pkg::ADDR_TIMEOUT: timeout_reg <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            efr_pkg::ADDR_ALPHA:   prdata = 32'(alpha_reg);
            efr_pkg::ADDR_STEP:    prdata = 32'(step_reg);
            efr_pkg::ADDR_TIMEOUT: prdata = 32'(timeout_reg);
            default:               prdata = '0;
        endcase
    end

    // A frame status item is pending from the edge after the last frame byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else if (cmd.byte_step && s_data.end_of_frame) begin
            pend_reg <= 1'b1;
        end else if (m_ready) begin
            pend_reg <= 1'b0;
        end
    end

    assign s_ready = ctrl_ready && !pend_reg;
    assign m_valid = ctrl_valid || pend_reg;

    efr_ctrl #(.NUM_CHANNELS(NUM_CHANNELS)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid && !pend_reg),
        .s_ready  (ctrl_ready),
        .in_mode  (s_data.mode),
        .m_ready  (m_ready),
        .out_valid(ctrl_valid),
        .chan     (chan),
        .cmd      (cmd),
        .stat     (stat)
    );

    efr_datapath #(.NUM_CHANNELS(NUM_CHANNELS)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .chan         (chan),
        .byte_data    (s_data.byte_data),
        .end_of_frame (s_data.end_of_frame),
        .alpha_q8     (alpha_reg),
        .max_step_us  (step_reg),
        .timeout_limit(timeout_reg),
        .out_item     (m_data)
    );

endmodule
